[design/quaternion_arithmetic_unit_defines.svh]
// Assertion macros for the quaternion arithmetic unit.
// Used by qau_back, the RTL file that carries concurrent assertions; no dependencies.
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

// checked only outside reset
`define QAU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define QAU_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/qau_pkg.sv]
// Shared types, codes and tables of the quaternion arithmetic unit.
// No dependencies.
package qau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_MUL   = 3'd2;
	localparam logic [2:0] OP_SCALE = 3'd3;
	localparam logic [2:0] OP_NORM  = 3'd4;

	typedef enum logic [2:0] {
		K_ADD,
		K_SUB,
		K_MUL,
		K_SCALE,
		K_NORM,
		K_ZERO
	} kind_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
	} qhead_t;

	typedef struct packed {
		logic [1:0] a_idx;
		logic [1:0] b_idx;
		logic       neg;
	} term_t;

	// Hamilton product terms; step[3:2] selects the component (x y z w)
	function automatic term_t mul_term(input logic [3:0] step);
		term_t t;
		unique case (step)
			4'd0:  t = '{2'd3, 2'd0, 1'b0};
			4'd1:  t = '{2'd0, 2'd3, 1'b0};
			4'd2:  t = '{2'd1, 2'd2, 1'b0};
			4'd3:  t = '{2'd2, 2'd1, 1'b1};
			4'd4:  t = '{2'd3, 2'd1, 1'b0};
			4'd5:  t = '{2'd0, 2'd2, 1'b1};
			4'd6:  t = '{2'd1, 2'd3, 1'b0};
			4'd7:  t = '{2'd2, 2'd0, 1'b0};
			4'd8:  t = '{2'd3, 2'd2, 1'b0};
			4'd9:  t = '{2'd0, 2'd1, 1'b0};
			4'd10: t = '{2'd1, 2'd0, 1'b1};
			4'd11: t = '{2'd2, 2'd3, 1'b0};
			4'd12: t = '{2'd3, 2'd3, 1'b0};
			4'd13: t = '{2'd0, 2'd0, 1'b1};
			4'd14: t = '{2'd1, 2'd1, 1'b1};
			4'd15: t = '{2'd2, 2'd2, 1'b1};
		endcase
		return t;
	endfunction

endpackage

[design/qau_if.sv]
// Request and response channel interfaces of the quaternion arithmetic unit.
// Depends on qau_pkg for default widths.
interface qau_req_if #(parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF) ();
	logic                         valid;
	logic                         ready;
	logic [2:0]                   req_type;
	logic signed [DATA_WIDTH-1:0] a_x;
	logic signed [DATA_WIDTH-1:0] a_y;
	logic signed [DATA_WIDTH-1:0] a_z;
	logic signed [DATA_WIDTH-1:0] a_w;
	logic signed [DATA_WIDTH-1:0] b_x;
	logic signed [DATA_WIDTH-1:0] b_y;
	logic signed [DATA_WIDTH-1:0] b_z;
	logic signed [DATA_WIDTH-1:0] b_w;
	logic signed [DATA_WIDTH-1:0] scale_factor;

	modport source (output valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
		scale_factor, input ready);
	modport sink (input valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
		scale_factor, output ready);
endinterface

interface qau_rsp_if #(parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] r_x;
	logic signed [DATA_WIDTH-1:0] r_y;
	logic signed [DATA_WIDTH-1:0] r_z;
	logic signed [DATA_WIDTH-1:0] r_w;
	logic                         overflow;
	logic                         zero_magnitude;

	modport source (output valid, r_x, r_y, r_z, r_w, overflow, zero_magnitude,
		input ready);
	modport sink (input valid, r_x, r_y, r_z, r_w, overflow, zero_magnitude,
		output ready);
endinterface

[design/quaternion_arithmetic_unit.sv]
// Quaternion arithmetic unit, top level: decode queue front end and execution back end.
// Depends on qau_pkg, qau_if, qau_front and qau_back.
//
// Request channel req carries req_type, quaternions a and b and scale_factor in signed
// fixed point; response channel rsp returns r_x..r_w, overflow and zero_magnitude, one
// item per request, in order. Both are valid/ready; an item moves when both are high.
// The front queues up to two decoded items, so requests keep flowing while the back end
// works or the response waits. The back end runs one item at a time on one multiplier:
//   add, subtract: computed straight from the queue head; undefined code: zero result
//   scale:     4 products
//   multiply:  16 products
//   normalize: 4 squares, DATA_WIDTH+1 square root steps, then 4 divisions
// The multiplier is shared, and the square root and divider produce one result bit per step.
// A stalled response holds in the output register; the back end waits behind it and the
// queue fills, after which req.ready drops. Reset empties the queue and the output.
module quaternion_arithmetic_unit #(
	parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	qau_req_if.sink   req,
	qau_rsp_if.source rsp
);

	qau_pkg::qhead_t              head;
	logic signed [DATA_WIDTH-1:0] head_a [4];
	logic signed [DATA_WIDTH-1:0] head_b [4];
	logic signed [DATA_WIDTH-1:0] head_s;
	logic                         head_pop;

	qau_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.head     (head),
		.head_a   (head_a),
		.head_b   (head_b),
		.head_s   (head_s),
		.head_pop (head_pop)
	);

	qau_back #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_a   (head_a),
		.head_b   (head_b),
		.head_s   (head_s),
		.head_pop (head_pop),
		.rsp      (rsp)
	);

endmodule

[design/qau_front.sv]
// Front end: accepts request items, decodes the operation, holds them in a short queue.
// Depends on qau_pkg and qau_req_if.
module qau_front #(
	parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	qau_req_if.sink                      req,
	output qau_pkg::qhead_t              head,
	output logic signed [DATA_WIDTH-1:0] head_a [4],
	output logic signed [DATA_WIDTH-1:0] head_b [4],
	output logic signed [DATA_WIDTH-1:0] head_s,
	input  logic                         head_pop
);

	localparam int DEPTH = qau_pkg::QUEUE_DEPTH;
	localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	logic signed [DATA_WIDTH-1:0] ent_a_q [DEPTH][4];
	logic signed [DATA_WIDTH-1:0] ent_b_q [DEPTH][4];
	logic signed [DATA_WIDTH-1:0] ent_s_q [DEPTH];
	qau_pkg::kind_t               ent_kind_q [DEPTH];
	logic [PTRW-1:0]              wr_ptr_q;
	logic [PTRW-1:0]              rd_ptr_q;
	logic [CNTW-1:0]              cnt_q;
	logic                         push;
	logic                         pop;
	qau_pkg::kind_t               kind_in;

	always_comb begin
		unique case (req.req_type)
			qau_pkg::OP_ADD:   kind_in = qau_pkg::K_ADD;
			qau_pkg::OP_SUB:   kind_in = qau_pkg::K_SUB;
			qau_pkg::OP_MUL:   kind_in = qau_pkg::K_MUL;
			qau_pkg::OP_SCALE: kind_in = qau_pkg::K_SCALE;
			qau_pkg::OP_NORM:  kind_in = qau_pkg::K_NORM;
			default:           kind_in = qau_pkg::K_ZERO;
		endcase
	end

	assign req.ready  = (cnt_q != CNTW'(DEPTH));
	assign push       = req.valid && req.ready;
	assign pop        = head_pop && head.valid;
	assign head.valid = (cnt_q != '0);
	assign head.kind  = ent_kind_q[rd_ptr_q];
	assign head_a     = ent_a_q[rd_ptr_q];
	assign head_b     = ent_b_q[rd_ptr_q];
	assign head_s     = ent_s_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_kind_q[wr_ptr_q] <= kind_in;
			ent_a_q[wr_ptr_q]    <= '{req.a_x, req.a_y, req.a_z, req.a_w};
			ent_b_q[wr_ptr_q]    <= '{req.b_x, req.b_y, req.b_z, req.b_w};
			ent_s_q[wr_ptr_q]    <= req.scale_factor;
		end
	end

endmodule

[design/qau_back.sv]
// Back end: executes one queued item at a time on a shared multiplier,
// digit-serial square root and divider, and holds the result register.
// Depends on qau_pkg, qau_rsp_if and quaternion_arithmetic_unit_defines.svh.
`include "quaternion_arithmetic_unit_defines.svh"

module qau_back #(
	parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qau_pkg::qhead_t              head,
	input  logic signed [DATA_WIDTH-1:0] head_a [4],
	input  logic signed [DATA_WIDTH-1:0] head_b [4],
	input  logic signed [DATA_WIDTH-1:0] head_s,
	output logic                         head_pop,
	qau_rsp_if.source                    rsp
);

	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int PW = 2 * DW;
	localparam int AW = 2 * DW + 2;
	localparam int RW = DW + 1;
	localparam int NW = DW + FB + 1;
	localparam int CW = $clog2(NW + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAC  = 3'd1;
	localparam logic [2:0] S_RND  = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;
	localparam logic [2:0] S_DLD  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	localparam logic [CW-1:0] N_MUL = CW'(16);
	localparam logic [CW-1:0] N_VEC = CW'(4);

	localparam logic signed [AW-1:0] RND_C = {{(AW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
	localparam logic signed [AW-1:0] SMAX  = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [AW-1:0] SMIN  = ~SMAX;
	localparam logic [NW-1:0]        QMAX  = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [NW-1:0]        QMINM = QMAX + 1'b1;
	localparam logic signed [DW-1:0] DMAX  = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] DMIN  = {1'b1, {(DW-1){1'b0}}};

	logic [2:0]                   state_q;
	logic [CW-1:0]                step_q;
	logic [1:0]                   comp_q;
	qau_pkg::kind_t               kind_q;
	logic signed [DW-1:0]         a_q [4];
	logic signed [DW-1:0]         b_q [4];
	logic signed [DW-1:0]         s_q;
	logic signed [AW-1:0]         acc_q [4];
	logic signed [PW-1:0]         prod_s1;
	logic                         valid_s1;
	logic [1:0]                   dst_s1;
	logic                         neg_s1;
	logic [AW-1:0]                rad_q;
	logic [RW-1:0]                root_q;
	logic [RW:0]                  srem_q;
	logic [RW-1:0]                m_q;
	logic [NW-1:0]                dnum_q;
	logic [RW-1:0]                drem_q;
	logic [NW-1:0]                quo_q;
	logic signed [DW-1:0]         res_q [4];
	logic                         ovf_q;
	logic                         zm_q;
	logic signed [DW-1:0]         out_r_q [4];
	logic                         out_ovf_q;
	logic                         out_zm_q;
	logic                         out_valid_q;

	logic [CW-1:0]                n_steps;
	qau_pkg::term_t               term;
	logic signed [DW-1:0]         op1;
	logic signed [DW-1:0]         op2;
	logic [1:0]                   dst;
	logic                         neg;
	logic                         mac_issue;
	logic                         mac_done;
	logic signed [AW-1:0]         prod_ext;
	logic signed [DW-1:0]         as_res [4];
	logic [3:0]                   as_ovf;
	logic signed [DW-1:0]         rnd_res [4];
	logic [3:0]                   rnd_ovf;
	logic [RW+1:0]                srt_rem;
	logic [RW+1:0]                srt_trial;
	logic                         srt_ge;
	logic [RW-1:0]                root_nx;
	logic [RW+1:0]                srem_nx;
	logic                         srt_last;
	logic signed [DW-1:0]         a_sel;
	logic [DW-1:0]                a_abs;
	logic [NW-1:0]                dnum_ld;
	logic [RW:0]                  div_rem;
	logic                         div_ge;
	logic [RW:0]                  drem_nx;
	logic [NW-1:0]                quo_nx;
	logic [NW-1:0]                quo_neg;
	logic                         div_last;
	logic signed [DW-1:0]         div_res;
	logic                         div_ovf;
	logic                         out_load;

	assign head_pop = (state_q == S_IDLE) && head.valid;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// multiplier operand selection
	always_comb begin
		n_steps = (kind_q == qau_pkg::K_MUL) ? N_MUL : N_VEC;
		term    = qau_pkg::mul_term(step_q[3:0]);
		unique case (kind_q)
			qau_pkg::K_MUL: begin
				op1 = a_q[term.a_idx];
				op2 = b_q[term.b_idx];
				dst = step_q[3:2];
				neg = term.neg;
			end
			qau_pkg::K_SCALE: begin
				op1 = a_q[step_q[1:0]];
				op2 = s_q;
				dst = step_q[1:0];
				neg = 1'b0;
			end
			default: begin
				op1 = a_q[step_q[1:0]];
				op2 = a_q[step_q[1:0]];
				dst = 2'd0;
				neg = 1'b0;
			end
		endcase
	end

	assign mac_issue = (state_q == S_MAC) && (step_q < n_steps);
	assign mac_done  = (state_q == S_MAC) && (step_q == n_steps) && !valid_s1;
	assign prod_ext  = AW'(prod_s1);

	// add / subtract straight from the queue head
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic signed [DW:0] sum;
			sum = (head.kind == qau_pkg::K_SUB) ? ((DW+1)'(head_a[i]) - (DW+1)'(head_b[i]))
				: ((DW+1)'(head_a[i]) + (DW+1)'(head_b[i]));
			as_ovf[i] = sum[DW] ^ sum[DW-1];
			as_res[i] = as_ovf[i] ? (sum[DW] ? DMIN : DMAX) : sum[DW-1:0];
		end
	end

	// round half up and saturate the accumulators
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic signed [AW-1:0] rs;
			rs = (acc_q[i] + RND_C) >>> FB;
			if (rs > SMAX) begin
				rnd_res[i] = DMAX;
				rnd_ovf[i] = 1'b1;
			end else if (rs < SMIN) begin
				rnd_res[i] = DMIN;
				rnd_ovf[i] = 1'b1;
			end else begin
				rnd_res[i] = rs[DW-1:0];
				rnd_ovf[i] = 1'b0;
			end
		end
	end

	// square root, two radicand bits per step
	assign srt_rem   = {srem_q[RW-1:0], rad_q[AW-1 -: 2]};
	assign srt_trial = {1'b0, root_q[RW-2:0], 2'b01};
	assign srt_ge    = (srt_rem >= srt_trial);
	assign root_nx   = {root_q[RW-2:0], srt_ge};
	assign srem_nx   = srt_ge ? (srt_rem - srt_trial) : srt_rem;
	assign srt_last  = (step_q == CW'(RW - 1));

	// restoring divider, one quotient bit per step
	assign a_sel    = a_q[comp_q];
	assign a_abs    = a_sel[DW-1] ? DW'(-a_sel) : DW'(a_sel);
	assign dnum_ld  = NW'({a_abs, {FB{1'b0}}}) + NW'(m_q >> 1);
	assign div_rem  = {drem_q, dnum_q[NW-1]};
	assign div_ge   = (div_rem >= {1'b0, m_q});
	assign drem_nx  = div_ge ? (div_rem - {1'b0, m_q}) : div_rem;
	assign quo_nx   = {quo_q[NW-2:0], div_ge};
	assign quo_neg  = -quo_nx;
	assign div_last = (step_q == CW'(NW - 1));

	always_comb begin
		if (!a_sel[DW-1]) begin
			div_ovf = (quo_nx > QMAX);
			div_res = div_ovf ? DMAX : quo_nx[DW-1:0];
		end else begin
			div_ovf = (quo_nx > QMINM);
			div_res = div_ovf ? DMIN : quo_neg[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			comp_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= mac_issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					comp_q <= '0;
					if (head.valid) begin
						unique case (head.kind)
							qau_pkg::K_MUL, qau_pkg::K_SCALE, qau_pkg::K_NORM:
								state_q <= S_MAC;
							default:
								state_q <= S_DONE;
						endcase
					end
				end
				S_MAC: begin
					if (mac_issue) begin
						step_q <= step_q + 1'b1;
					end
					if (mac_done) begin
						step_q  <= '0;
						state_q <= (kind_q == qau_pkg::K_NORM) ? S_SQRT : S_RND;
					end
				end
				S_RND: state_q <= S_DONE;
				S_SQRT: begin
					if (srt_last) begin
						step_q  <= '0;
						state_q <= (root_nx == '0) ? S_DONE : S_DLD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DLD: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (div_last) begin
						comp_q  <= comp_q + 1'b1;
						state_q <= (comp_q == 2'd3) ? S_DONE : S_DLD;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mac_issue) begin
			prod_s1 <= op1 * op2;
			dst_s1  <= dst;
			neg_s1  <= neg;
		end
		if (state_q == S_IDLE && head.valid) begin
			a_q    <= head_a;
			b_q    <= head_b;
			s_q    <= head_s;
			kind_q <= head.kind;
			acc_q  <= '{default: '0};
			zm_q   <= 1'b0;
			if (head.kind == qau_pkg::K_ADD || head.kind == qau_pkg::K_SUB) begin
				res_q <= as_res;
				ovf_q <= |as_ovf;
			end else begin
				res_q <= '{default: '0};
				ovf_q <= 1'b0;
			end
		end
		if (state_q == S_MAC && valid_s1) begin
			acc_q[dst_s1] <= neg_s1 ? (acc_q[dst_s1] - prod_ext) : (acc_q[dst_s1] + prod_ext);
		end
		if (mac_done) begin
			rad_q  <= acc_q[0];
			root_q <= '0;
			srem_q <= '0;
		end
		if (state_q == S_RND) begin
			res_q <= rnd_res;
			ovf_q <= |rnd_ovf;
		end
		if (state_q == S_SQRT) begin
			rad_q  <= rad_q << 2;
			root_q <= root_nx;
			srem_q <= srem_nx[RW:0];
			if (srt_last) begin
				m_q <= root_nx;
				if (root_nx == '0) begin
					zm_q <= 1'b1;
				end
			end
		end
		if (state_q == S_DLD) begin
			dnum_q <= dnum_ld;
			drem_q <= '0;
			quo_q  <= '0;
		end
		if (state_q == S_DIV) begin
			dnum_q <= dnum_q << 1;
			drem_q <= drem_nx[RW-1:0];
			quo_q  <= quo_nx;
			if (div_last) begin
				res_q[comp_q] <= div_res;
				ovf_q         <= ovf_q | div_ovf;
			end
		end
		if (out_load) begin
			out_r_q   <= res_q;
			out_ovf_q <= ovf_q;
			out_zm_q  <= zm_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.r_x            = out_r_q[0];
	assign rsp.r_y            = out_r_q[1];
	assign rsp.r_z            = out_r_q[2];
	assign rsp.r_w            = out_r_q[3];
	assign rsp.overflow       = out_ovf_q;
	assign rsp.zero_magnitude = out_zm_q;

	`QAU_ASSERT(a_zm_clean, clk, arst_n, rsp.valid && rsp.zero_magnitude |-> !rsp.overflow && rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0 && rsp.r_w == '0, "zero magnitude result not clean")
	`QAU_ASSERT(a_pop_idle, clk, arst_n, head_pop |=> state_q != S_IDLE, "queue popped without starting an item")
	`QAU_ASSERT(a_div_nonzero, clk, arst_n, state_q == S_DIV || state_q == S_DLD |-> m_q != '0, "divide by zero magnitude")
	`QAU_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> state_q == S_IDLE && !out_valid_q, "back end not idle in reset")

endmodule
